### rtl/dold_pkg.sv
// Package: shared types and constants for the delimiter-or-length deframer.
package dold_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 16;
    localparam int DELIM_W   = 64;
    localparam int DLEN_W    = 4;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;

    // Framing modes
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELIM = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OFF  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAMING_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_CAPACITY   = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]  framing_mode;
        logic [COUNT_W-1:0] target_count;
        logic [DELIM_W-1:0] delimiter_bytes;
        logic [DLEN_W-1:0]  delimiter_length;
        logic [COUNT_W-1:0] frame_capacity;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   byte_out;
        logic [STATUS_W-1:0] status;
        logic                frame_end;
        logic [COUNT_W-1:0]  frame_bytes;
    } result_t;

endpackage

### rtl/dold_if.sv
// Interfaces: byte input channel and result channel with valid/ready handshake.
interface dold_in_if;
    import dold_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface dold_out_if;
    import dold_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   byte_out;
    logic [STATUS_W-1:0] status;
    logic                frame_end;
    logic [COUNT_W-1:0]  frame_bytes;

    modport source (output valid, output byte_out, output status, output frame_end,
                    output frame_bytes, input ready);
    modport sink   (input valid, input byte_out, input status, input frame_end,
                    input frame_bytes, output ready);
endinterface

### rtl/dold_cfg_regs.sv
// Configuration register file with write-only access.
module dold_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dold_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dold_pkg::DELIM_W-1:0]     cfg_wdata,
    output dold_pkg::cfg_t                   cfg
);
    import dold_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.framing_mode     <= MODE_OFF;
            cfg_reg.target_count     <= COUNT_W'(1);
            cfg_reg.delimiter_bytes  <= '0;
            cfg_reg.delimiter_length <= DLEN_W'(1);
            cfg_reg.frame_capacity   <= '1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FRAMING_MODE:     cfg_reg.framing_mode     <= cfg_wdata[MODE_W-1:0];
                REG_TARGET_COUNT:     cfg_reg.target_count     <= cfg_wdata[COUNT_W-1:0];
                REG_DELIMITER_BYTES:  cfg_reg.delimiter_bytes  <= cfg_wdata;
                REG_DELIMITER_LENGTH: cfg_reg.delimiter_length <= cfg_wdata[DLEN_W-1:0];
                REG_FRAME_CAPACITY:   cfg_reg.frame_capacity   <= cfg_wdata[COUNT_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/dold_frame_core.sv
// Frame state (fill count, recent-byte window) and per-byte evaluation.
module dold_frame_core #(
    parameter int MAX_DELIM_BYTES = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dold_pkg::cfg_t               cfg,
    input  logic                         step,
    input  logic [dold_pkg::BYTE_W-1:0]  data_byte,
    output dold_pkg::result_t            res
);
    import dold_pkg::*;

    localparam int WIN_W = BYTE_W * MAX_DELIM_BYTES;
    localparam logic [DLEN_W-1:0] MAX_N = DLEN_W'(MAX_DELIM_BYTES);

    logic [COUNT_W-1:0]      fill_reg;
    logic [COUNT_W-1:0]      fill_next;
    logic [WIN_W-1:0]        window_reg;
    logic [WIN_W-1:0]        window_next;
    logic [COUNT_W-1:0]      fill_inc;
    logic [WIN_W+BYTE_W-1:0] win_shift;
    logic [WIN_W-1:0]        win_new;
    logic [DLEN_W-1:0]       n_cmp;
    logic                    delim_hit;
    logic                    take;

    always_comb
    begin
        fill_inc  = fill_reg + COUNT_W'(1);
        win_shift = {window_reg, data_byte};
        win_new   = win_shift[WIN_W-1:0];

        // clamp compare length to 1..MAX_DELIM_BYTES
        if (cfg.delimiter_length == '0)
            n_cmp = DLEN_W'(1);
        else if (cfg.delimiter_length > MAX_N)
            n_cmp = MAX_N;
        else
            n_cmp = cfg.delimiter_length;

        // lanes beyond the compare length always pass
        delim_hit = 1'b1;
        for (int k = 0; k < MAX_DELIM_BYTES; k++)
        begin
            if (DLEN_W'(k) < n_cmp &&
                win_new[BYTE_W*k +: BYTE_W] != cfg.delimiter_bytes[BYTE_W*k +: BYTE_W])
                delim_hit = 1'b0;
        end

        res.byte_out    = data_byte;
        res.status      = ST_OK;
        res.frame_end   = 1'b0;
        res.frame_bytes = fill_reg;
        take            = 1'b0;

        if (cfg.framing_mode != MODE_COUNT && cfg.framing_mode != MODE_DELIM)
            res.status = ST_OFF;
        else if (fill_reg >= cfg.frame_capacity)
            res.status = ST_FULL;
        else
        begin
            take            = 1'b1;
            res.frame_bytes = fill_inc;
            if (cfg.framing_mode == MODE_COUNT)
                res.frame_end = (fill_inc >= cfg.target_count);
            else
                res.frame_end = (fill_inc >= COUNT_W'(n_cmp)) && delim_hit;
        end

        fill_next   = fill_reg;
        window_next = window_reg;
        if (step && take)
        begin
            if (res.frame_end)
            begin
                fill_next   = '0;
                window_next = '0;
            end
            else
            begin
                fill_next   = fill_inc;
                window_next = win_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            window_reg <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            window_reg <= window_next;
        end
    end

endmodule

### rtl/delimiter_or_length_deframer.sv
// Top level: byte-stream deframer, count or delimiter framing, one byte per clock.
// Path from input accept to result valid: input register -> result register.
// Throughput: one word per clock while the result side keeps up; the delimiter compare across all lanes is parallel.
// Back-pressure only stalls when both input and result registers hold words.
// Reset (rst_n, async, active low): registers return to defaults, frame empty,
// both pipeline registers empty.
module delimiter_or_length_deframer #(
    parameter int MAX_DELIM_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dold_in_if.sink                         stream,
    dold_out_if.source                      result,
    input  logic                            cfg_wr_en,
    input  logic [dold_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dold_pkg::DELIM_W-1:0]    cfg_wdata
);
    import dold_pkg::*;

    cfg_t               cfg;
    result_t            core_res;
    result_t            res_reg;
    logic               res_valid_reg;
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_take;
    logic               advance;

    // Word moves from input register to result register when the result slot
    // is free or drains in the same cycle; frame state updates on that move.
    assign advance      = in_valid_reg && (!res_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || advance;
    assign in_take      = stream.valid && stream.ready;

    dold_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dold_frame_core #(
        .MAX_DELIM_BYTES (MAX_DELIM_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (advance),
        .data_byte (in_byte_reg),
        .res       (core_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= stream.data_byte;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= core_res;
    end

    assign result.valid       = res_valid_reg;
    assign result.byte_out    = res_reg.byte_out;
    assign result.status      = res_reg.status;
    assign result.frame_end   = res_reg.frame_end;
    assign result.frame_bytes = res_reg.frame_bytes;

    // A frame end only comes with an accepted byte and a nonzero length.
    a_end_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.frame_end) |->
            (res_reg.status == ST_OK && res_reg.frame_bytes != '0))
        else $error("frame end on rejected byte or empty frame");

    // A held input word stays put until it moves on.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register lost or changed a stalled word");

    // A move lands the echoed byte in the result register.
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (res_valid_reg && res_reg.byte_out == $past(in_byte_reg)))
        else $error("result register does not echo the moved byte");

endmodule

### bench/delimiter_or_length_deframer_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the byte deframer: directed steps, then randomized framing phases.
module delimiter_or_length_deframer_tb;
    import dold_pkg::*;

    localparam int MAX_DELIM     = 8;
    // ~2000 words; worst case per word is the longest send gap plus the longest
    // sink stall plus the pass through both pipe registers; config drains add little.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASES        = 13;
    localparam int PHASE_WORDS   = 150;
    localparam int TAIL_CYCLES   = 10;
    localparam int ERR_PRINT_MAX = 200;

    // Mode code 3 has no name in the package; the block treats it as not armed.
    localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
    // Index past the last register: writes here must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // One row of the directed table: a register write or one input word,
    // optionally with its result typed in by hand.
    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] idx;
        logic [DELIM_W-1:0]   wdata;
        logic [BYTE_W-1:0]    data;
        logic                 typed;
        result_t              want;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DELIM_W-1:0]   cfg_wdata;

    dold_in_if  stream_ch ();
    dold_out_if result_ch ();

    delimiter_or_length_deframer #(
        .MAX_DELIM_BYTES (MAX_DELIM)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the block's registers and frame state.
    logic [MODE_W-1:0]  mode_q;
    logic [COUNT_W-1:0] target_q;
    logic [DELIM_W-1:0] delim_q;
    logic [DLEN_W-1:0]  dlen_q;
    logic [COUNT_W-1:0] capacity_q;
    logic [COUNT_W-1:0] fill_q;
    logic [DELIM_W-1:0] window_q;

    result_t results_due[$];     // expected results, oldest first
    step_t   directed_steps[$];

    int error_count = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit src_gaps_on;
    bit sink_stalls_on;
    result_t seen;
    result_t due;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Delimiter length as compared: 0 counts as 1, anything above 8 as 8.
    function automatic int compare_width(input logic [DLEN_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_DELIM)
            return MAX_DELIM;
        return int'(len);
    endfunction

    // Works out the result for one accepted word and advances the frame state.
    function automatic result_t predict_framing(input logic [BYTE_W-1:0] b);
        result_t            r;
        logic [COUNT_W-1:0] nxt;
        logic [DELIM_W-1:0] win;
        logic [DELIM_W-1:0] mask;
        int                 n;
        r.byte_out    = b;
        r.status      = ST_OK;
        r.frame_end   = 1'b0;
        r.frame_bytes = fill_q;
        if (mode_q != MODE_COUNT && mode_q != MODE_DELIM)
            r.status = ST_OFF;
        else if (fill_q >= capacity_q)
            r.status = ST_FULL;     // rejected words leave the state alone
        else
        begin
            nxt = fill_q + 1'b1;
            win = {window_q[DELIM_W-BYTE_W-1:0], b};
            r.frame_bytes = nxt;
            if (mode_q == MODE_COUNT)
                r.frame_end = (nxt >= target_q);    // target 0 behaves as 1
            else
            begin
                n    = compare_width(dlen_q);
                mask = (n >= 8) ? '1 : (64'd1 << (8 * n)) - 64'd1;
                // match only counts once the frame holds the whole delimiter
                r.frame_end = (nxt >= n) && ((win & mask) == (delim_q & mask));
            end
            fill_q   = r.frame_end ? '0 : nxt;
            window_q = r.frame_end ? '0 : win;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= ERR_PRINT_MAX)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_pipe_empty();
        stream_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Register writes only go in with the pipe drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELIM_W-1:0] value);
        wait_pipe_empty();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FRAMING_MODE:     mode_q     = value[MODE_W-1:0];
            REG_TARGET_COUNT:     target_q   = value[COUNT_W-1:0];
            REG_DELIMITER_BYTES:  delim_q    = value;
            REG_DELIMITER_LENGTH: dlen_q     = value[DLEN_W-1:0];
            REG_FRAME_CAPACITY:   capacity_q = value[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // Drives one word, waits for the handshake, queues its expected result.
    // valid stays high into the next call unless a gap is inserted.
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic typed, input result_t want);
        result_t r;
        if (src_gaps_on && $urandom_range(0, 4) == 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        stream_ch.valid     <= 1'b1;
        stream_ch.data_byte <= b;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
        r = predict_framing(b);
        results_due.push_back(typed ? want : r);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [DELIM_W-1:0] value);
        step_t s;
        s          = '0;
        s.is_write = 1'b1;
        s.idx      = idx;
        s.wdata    = value;
        directed_steps.push_back(s);
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] b);
        step_t s;
        s      = '0;
        s.data = b;
        directed_steps.push_back(s);
    endtask

    task automatic add_known(input logic [BYTE_W-1:0] b, input logic [STATUS_W-1:0] st,
                             input logic fe, input logic [COUNT_W-1:0] fb);
        step_t s;
        s       = '0;
        s.data  = b;
        s.typed = 1'b1;
        s.want  = '{b, st, fe, fb};
        directed_steps.push_back(s);
    endtask

    // One random phase: fresh settings, then PHASE_WORDS words or a few more.
    task automatic run_phase(input int p);
        logic [MODE_W-1:0] mode;
        int                sel;
        int                sent;
        int                pay;
        int                n;
        // last two phases run flat out on both sides
        src_gaps_on    = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
        sink_stalls_on = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);

        if (p == 0)
            mode = MODE_COUNT;
        else if (p == 1)
            mode = MODE_DELIM;
        else
        begin
            sel = $urandom_range(0, 19);
            if (sel < 8)
                mode = MODE_COUNT;
            else if (sel < 17)
                mode = MODE_DELIM;
            else if (sel == 17)
                mode = MODE_OFF;
            else
                mode = MODE_SPARE;
        end

        case ($urandom_range(0, 3))
            0:       write_reg(REG_TARGET_COUNT, DELIM_W'($urandom_range(0, 20)));
            1:       write_reg(REG_TARGET_COUNT, DELIM_W'($urandom_range(1, 6)));
            2:       write_reg(REG_TARGET_COUNT, DELIM_W'($urandom_range(100, 400)));
            default: write_reg(REG_TARGET_COUNT, DELIM_W'(16'hFFFF));
        endcase
        case ($urandom_range(0, 5))
            0:       write_reg(REG_DELIMITER_BYTES, '1);
            1:       write_reg(REG_DELIMITER_BYTES, '0);
            default: write_reg(REG_DELIMITER_BYTES, {$urandom, $urandom});
        endcase
        write_reg(REG_DELIMITER_LENGTH, DELIM_W'($urandom_range(0, 15)));
        case ($urandom_range(0, 5))
            0:       write_reg(REG_FRAME_CAPACITY, DELIM_W'($urandom_range(0, 40)));
            1:       write_reg(REG_FRAME_CAPACITY, DELIM_W'($urandom_range(1, 16'hFFFF)));
            default: write_reg(REG_FRAME_CAPACITY, DELIM_W'(16'hFFFF));
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, {$urandom, $urandom});
        write_reg(REG_FRAMING_MODE, DELIM_W'(mode));

        sent = 0;
        while (sent < PHASE_WORDS)
        begin
            if (mode_q == MODE_DELIM && $urandom_range(0, 4) != 0)
            begin
                // well-formed frame: random payload closed by the delimiter,
                // oldest delimiter byte first
                pay = $urandom_range(0, 6);
                repeat (pay)
                begin
                    send_word(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                    sent++;
                end
                n = compare_width(dlen_q);
                for (int k = n - 1; k >= 0; k--)
                begin
                    send_word(delim_q[8 * k +: 8], 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                send_word(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                sent++;
            end
            // now and then hold off until the pipe is empty
            if ($urandom_range(0, 99) == 0)
                wait_pipe_empty();
        end
    endtask

    // Result sink: checks each accepted word against the oldest expectation
    // and throttles ready in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                seen = '{result_ch.byte_out, result_ch.status, result_ch.frame_end,
                         result_ch.frame_bytes};
                if (results_due.size() == 0)
                    report_mismatch($sformatf("result %h with nothing outstanding", seen));
                else
                begin
                    due = results_due.pop_front();
                    if (seen.byte_out !== due.byte_out)
                        report_mismatch($sformatf("byte_out %h, want %h",
                                                  seen.byte_out, due.byte_out));
                    if (seen.status !== due.status)
                        report_mismatch($sformatf("status %0d, want %0d (byte %h)",
                                                  seen.status, due.status, due.byte_out));
                    if (seen.frame_end !== due.frame_end)
                        report_mismatch($sformatf("frame_end %b, want %b (byte %h)",
                                                  seen.frame_end, due.frame_end, due.byte_out));
                    if (seen.frame_bytes !== due.frame_bytes)
                        report_mismatch($sformatf("frame_bytes %0d, want %0d (byte %h)",
                                                  seen.frame_bytes, due.frame_bytes,
                                                  due.byte_out));
                end
            end

            if (stall_left != 0)
            begin
                stall_left      <= stall_left - 1;
                result_ch.ready <= (stall_left == 1);
            end
            else if (sink_stalls_on && $urandom_range(0, 5) == 0)
            begin
                stall_left      <= $urandom_range(1, 15);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        step_t s;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = '0;
        cfg_wdata           = '0;
        stream_ch.valid     = 1'b0;
        stream_ch.data_byte = '0;

        // register defaults after reset, empty frame
        mode_q     = MODE_OFF;
        target_q   = 16'd1;
        delim_q    = '0;
        dlen_q     = 4'd1;
        capacity_q = 16'hFFFF;
        fill_q     = '0;
        window_q   = '0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;

        // straight out of reset nothing is armed
        add_known(8'h00, ST_OFF, 1'b0, 16'd0);
        add_known(8'hFF, ST_OFF, 1'b0, 16'd0);
        // mode 3 is not armed either
        add_write(REG_FRAMING_MODE, DELIM_W'(MODE_SPARE));
        add_known(8'hA5, ST_OFF, 1'b0, 16'd0);
        // zero target ends every frame on its first word
        add_write(REG_TARGET_COUNT, DELIM_W'(16'd0));
        add_write(REG_FRAMING_MODE, DELIM_W'(MODE_COUNT));
        add_known(8'h5A, ST_OK, 1'b1, 16'd1);
        // target cut below the fill mid-frame: next word closes the frame
        add_write(REG_TARGET_COUNT, DELIM_W'(16'd3));
        add_byte(8'h01);
        add_byte(8'h02);
        add_write(REG_TARGET_COUNT, DELIM_W'(16'd1));
        add_byte(8'h03);
        // target beyond capacity: fills up, then rejects as full
        add_write(REG_TARGET_COUNT, DELIM_W'(16'hFFFF));
        add_write(REG_FRAME_CAPACITY, DELIM_W'(16'd2));
        add_byte(8'h10);
        add_byte(8'h11);
        add_known(8'h12, ST_FULL, 1'b0, 16'd2);
        add_write(REG_FRAME_CAPACITY, DELIM_W'(16'd0));
        add_known(8'h13, ST_FULL, 1'b0, 16'd2);
        // reopen, close the frame by count, then zero capacity on an empty frame
        add_write(REG_FRAME_CAPACITY, DELIM_W'(16'hFFFF));
        add_write(REG_TARGET_COUNT, DELIM_W'(16'd3));
        add_byte(8'h14);
        add_write(REG_FRAME_CAPACITY, DELIM_W'(16'd0));
        add_known(8'h15, ST_FULL, 1'b0, 16'd0);
        // two-byte delimiter 00 0A: a lone 0A matches but the frame is too short
        add_write(REG_FRAME_CAPACITY, DELIM_W'(16'hFFFF));
        add_write(REG_DELIMITER_BYTES, 64'h0000_0000_0000_000A);
        add_write(REG_DELIMITER_LENGTH, DELIM_W'(4'd2));
        add_write(REG_FRAMING_MODE, DELIM_W'(MODE_DELIM));
        add_byte(8'h0A);
        add_byte(8'h00);
        add_byte(8'h0A);
        // length 0 compares one byte
        add_write(REG_DELIMITER_BYTES, 64'hFFFF_FFFF_FFFF_FF7E);
        add_write(REG_DELIMITER_LENGTH, DELIM_W'(4'd0));
        add_byte(8'h7E);
        // length 15 compares all eight bytes
        add_write(REG_DELIMITER_BYTES, 64'h0102_0304_0506_0708);
        add_write(REG_DELIMITER_LENGTH, DELIM_W'(4'hF));
        for (int k = 1; k < 8; k++)
            add_byte(k[7:0]);
        add_known(8'h08, ST_OK, 1'b1, 16'd8);
        // write to a nonexistent register must not disturb anything
        add_write(REG_UNUSED, '1);
        add_byte(8'h08);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            s = directed_steps[i];
            if (s.is_write)
                write_reg(s.idx, s.wdata);
            else
                send_word(s.data, s.typed, s.want);
        end

        for (int p = 0; p < PHASES; p++)
            run_phase(p);

        wait_pipe_empty();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
